FILE: hdl/kic_pkg.sv
// ----------------------------------------------------------------------------
// kic_pkg
// shared types and codes for the keypad integer calculator
// ----------------------------------------------------------------------------
package kic_pkg;

    localparam int VALUE_WIDTH = 16;

    // key kinds
    localparam logic [1:0] KEY_DIGIT    = 2'd0;
    localparam logic [1:0] KEY_OPERATOR = 2'd1;
    localparam logic [1:0] KEY_EQUALS   = 2'd2;
    localparam logic [1:0] KEY_CLEAR    = 2'd3;

    localparam logic [3:0] MAX_DIGIT = 4'd9;

    // latched operation codes
    localparam logic [2:0] PEND_NONE = 3'd0;
    localparam logic [2:0] PEND_DIV  = 3'd1;
    localparam logic [2:0] PEND_MUL  = 3'd2;
    localparam logic [2:0] PEND_SUB  = 3'd3;
    localparam logic [2:0] PEND_ADD  = 3'd4;

    // result events
    localparam logic [2:0] EV_IGNORED  = 3'd0;
    localparam logic [2:0] EV_DIGIT    = 3'd1;
    localparam logic [2:0] EV_OPERATOR = 3'd2;
    localparam logic [2:0] EV_RESULT   = 3'd3;
    localparam logic [2:0] EV_CLEARED  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIG_SHIFT,
        S_DIG_ADD,
        S_ADDSUB,
        S_MUL,
        S_ABS_A,
        S_ABS_B,
        S_DIV,
        S_FIX,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]                    event_res;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          divide_error;
    } t_res;

endpackage

FILE: hdl/kic_if.sv
// ----------------------------------------------------------------------------
// kic_if
// key and result channels of the keypad integer calculator
// ----------------------------------------------------------------------------
interface kic_key_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [3:0] digit;
    logic [1:0] operation;

    modport source (output valid, output op, output digit, output operation, input ready);
    modport sink   (input valid, input op, input digit, input operation, output ready);
endinterface

interface kic_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic signed [15:0] value;
    logic               divide_error;

    modport source (output valid, output event_res, output value, output divide_error,
                    input ready);
    modport sink   (input valid, input event_res, input value, input divide_error,
                    output ready);
endinterface

FILE: hdl/kic_alu.sv
// ----------------------------------------------------------------------------
// kic_alu
// shared adder / subtractor with carry out
// ----------------------------------------------------------------------------
module kic_alu #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic [OPERAND_WIDTH-1:0] i_x,
    input  logic [OPERAND_WIDTH-1:0] i_y,
    input  logic                     i_sub,
    output logic [OPERAND_WIDTH-1:0] o_sum,
    output logic                     o_carry
);
    logic [OPERAND_WIDTH:0]   w_full;
    logic [OPERAND_WIDTH-1:0] w_y;

    // subtract is x + ~y + 1, carry high means no borrow
    assign w_y    = i_sub ? ~i_y : i_y;
    assign w_full = {1'b0, i_x} + {1'b0, w_y} + (OPERAND_WIDTH + 1)'(i_sub);
    assign o_sum   = w_full[OPERAND_WIDTH-1:0];
    assign o_carry = w_full[OPERAND_WIDTH];
endmodule

FILE: hdl/kic_core.sv
// ----------------------------------------------------------------------------
// kic_core
// operand registers and sequencer around the shared adder
// ----------------------------------------------------------------------------
module kic_core
    import kic_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_op,
    input  logic [3:0] i_digit,
    input  logic [1:0] i_operation,
    output logic       o_idle,
    output logic       o_res_valid,
    output t_res       o_res,
    input  logic       i_res_take
);
    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(OPERAND_WIDTH);

    t_state r_state, n_state;
    logic [W-1:0]  r_a, n_a, r_b, n_b, r_acc, n_acc, r_q, n_q;
    logic          r_oe, n_oe, r_rs, n_rs, r_neg, n_neg;
    logic [2:0]    r_pend, n_pend;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [3:0]    r_dig, n_dig;
    t_res          r_res, n_res;

    logic [W-1:0] alu_x, alu_y, alu_sum, target, rem_sh, fin_val;
    logic         alu_sub, alu_carry, fin_en, last;

    kic_alu #(.OPERAND_WIDTH(W)) u_alu (
        .i_x     (alu_x),
        .i_y     (alu_y),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    assign target = r_oe ? r_b : r_a;
    assign rem_sh = {r_acc[W-2:0], r_q[W-1]};
    assign last   = (r_cnt == CW'(W - 1));

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_q     = r_q;
        n_oe    = r_oe;
        n_rs    = r_rs;
        n_neg   = r_neg;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_dig   = r_dig;
        n_res   = r_res;
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
        fin_en  = 1'b0;
        fin_val = r_a;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res   = '{EV_IGNORED, '0, 1'b0};
                    n_state = S_DONE;
                    n_cnt   = '0;
                    case (i_op)
                        KEY_DIGIT: begin
                            if (i_digit <= MAX_DIGIT) begin
                                n_dig   = i_digit;
                                n_state = S_DIG_SHIFT;
                            end
                        end
                        KEY_OPERATOR: begin
                            if (!r_oe || r_rs) begin
                                n_oe   = 1'b1;
                                n_rs   = 1'b0;
                                n_pend = 3'(i_operation) + PEND_DIV;
                                n_res.event_res = EV_OPERATOR;
                            end
                        end
                        KEY_EQUALS: begin
                            n_neg = r_a[W-1] ^ r_b[W-1];
                            case (r_pend) inside
                                PEND_DIV: begin
                                    if (r_b == '0) begin
                                        // divide by zero keeps the first operand
                                        fin_en  = 1'b1;
                                        fin_val = r_a;
                                    end else begin
                                        n_state = S_ABS_A;
                                    end
                                end
                                PEND_MUL: begin
                                    n_acc   = '0;
                                    n_q     = r_a;
                                    n_state = S_MUL;
                                end
                                PEND_SUB, PEND_ADD: n_state = S_ADDSUB;
                                default: ;
                            endcase
                        end
                        default: begin
                            n_a  = '0;
                            n_b  = '0;
                            n_oe = 1'b0;
                            n_rs = 1'b0;
                            n_res.event_res = EV_CLEARED;
                        end
                    endcase
                end
            end
            S_DIG_SHIFT: begin
                // x*8 + x*2
                alu_x   = target << 3;
                alu_y   = target << 1;
                n_acc   = alu_sum;
                n_state = S_DIG_ADD;
            end
            S_DIG_ADD: begin
                alu_x = r_acc;
                alu_y = W'(r_dig);
                if (r_oe) begin
                    n_b = alu_sum;
                end else begin
                    n_a = alu_sum;
                end
                n_res.event_res = EV_DIGIT;
                n_state = S_DONE;
            end
            S_ADDSUB: begin
                alu_x   = r_a;
                alu_y   = r_b;
                alu_sub = (r_pend == PEND_SUB);
                fin_en  = 1'b1;
                fin_val = alu_sum;
            end
            S_MUL: begin
                // shift-add, multiplier bits taken from the second operand
                alu_x = r_acc;
                alu_y = r_b[0] ? r_q : '0;
                n_acc = alu_sum;
                n_q   = r_q << 1;
                n_b   = r_b >> 1;
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    fin_en  = 1'b1;
                    fin_val = alu_sum;
                end
            end
            S_ABS_A: begin
                alu_y   = r_a;
                alu_sub = 1'b1;
                n_q     = r_a[W-1] ? alu_sum : r_a;
                n_acc   = '0;
                n_state = S_ABS_B;
            end
            S_ABS_B: begin
                alu_y   = r_b;
                alu_sub = 1'b1;
                n_b     = r_b[W-1] ? alu_sum : r_b;
                n_state = S_DIV;
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                alu_x   = rem_sh;
                alu_y   = r_b;
                alu_sub = 1'b1;
                n_acc   = alu_carry ? alu_sum : rem_sh;
                n_q     = {r_q[W-2:0], alu_carry};
                n_cnt   = r_cnt + 1'b1;
                if (last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                alu_y   = r_q;
                alu_sub = 1'b1;
                fin_en  = 1'b1;
                fin_val = r_neg ? alu_sum : r_q;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (fin_en) begin
            n_a   = fin_val;
            n_b   = '0;
            n_rs  = 1'b1;
            n_res = '{EV_RESULT, VALUE_WIDTH'(fin_val),
                      (r_state == S_IDLE)};
            n_state = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a     <= '0;
            r_b     <= '0;
            r_oe    <= 1'b0;
            r_rs    <= 1'b0;
            r_pend  <= PEND_NONE;
        end else begin
            r_state <= n_state;
            r_a     <= n_a;
            r_b     <= n_b;
            r_oe    <= n_oe;
            r_rs    <= n_rs;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_q   <= n_q;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_dig <= n_dig;
        r_res <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
endmodule

FILE: hdl/keypad_integer_calculator_top.sv
// ----------------------------------------------------------------------------
// keypad_integer_calculator_top
// four-function integer calculator driven by decoded key words
// ----------------------------------------------------------------------------
// i_key carries one key word (op, digit, operation) per valid/ready handshake;
// o_res returns exactly one result word (event_res, value, divide_error) for
// every key word accepted, in order.
// the block works on one key at a time; i_key.ready is high only while the
// sequencer is idle. all operand arithmetic goes through one shared adder.
// steps per key kind:
//   operator, clear, ignored keys : straight to the result
//   digit                         : x*8 + x*2, then + d
//   add, subtract                 : a + b or a - b through the adder
//   multiply                      : shift-add over the second operand's bits
//   divide                        : magnitudes, restoring steps, then sign fix
// divide by zero returns at once with divide_error set
// the sequencer returns to idle as its result is loaded into the output
// register, and can then take the next key.
// the output register decouples the sides: the next key is taken while a
// result still waits; if o_res stays stalled the sequencer holds its next
// result and stays busy until the register frees up.
// synchronous active-low reset zeroes operands and flags, clears the latched
// operation and drops o_res.valid
// ----------------------------------------------------------------------------
module keypad_integer_calculator_top
    import kic_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kic_key_if.sink    i_key,
    kic_res_if.source  o_res
);
    logic core_idle;
    logic core_valid;
    t_res core_res;
    logic load;
    logic r_out_valid;
    t_res r_out;

    kic_core #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_key.valid && core_idle),
        .i_op        (i_key.op),
        .i_digit     (i_key.digit),
        .i_operation (i_key.operation),
        .o_idle      (core_idle),
        .o_res_valid (core_valid),
        .o_res       (core_res),
        .i_res_take  (load)
    );

    assign i_key.ready = core_idle;

    // output register loads when empty or being drained this cycle
    assign load = core_valid && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.event_res    = r_out.event_res;
    assign o_res.value        = r_out.value;
    assign o_res.divide_error = r_out.divide_error;

`ifndef ASSERT_OFF
    // divide error only comes with a shown result
    a_derr_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.divide_error |-> o_res.event_res == EV_RESULT)
        else $error("divide error without result event");

    // value is zero unless a result is shown
    a_value_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.event_res != EV_RESULT |-> o_res.value == '0)
        else $error("nonzero value on non-result event");

    // an accepted key always takes the sequencer out of idle
    a_busy_after_key : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_key.valid && i_key.ready |=> !i_key.ready)
        else $error("ready stayed high after a key was accepted");
`endif
endmodule

FILE: bench/keypad_integer_calculator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_integer_calculator_top_test
// self-checking bench: key words in, one result word out per key, checked in
// order against a cycle-free calculator predictor kept inside the bench
// ----------------------------------------------------------------------------
module keypad_integer_calculator_top_test;
    import kic_pkg::*;

    // operator codes carried in the operation field of a key word
    localparam logic [1:0] OPR_DIVIDE   = 2'd0;
    localparam logic [1:0] OPR_MULTIPLY = 2'd1;
    localparam logic [1:0] OPR_SUBTRACT = 2'd2;
    localparam logic [1:0] OPR_ADD      = 2'd3;

    localparam logic [15:0] DECIMAL_BASE = 16'd10;
    localparam int          KEY_TARGET   = 1000;   // keys that change something
    localparam int          CALM_FROM    = 850;    // no idling from here on
    localparam int          HOLD_CYCLES  = 200;    // long result stall
    localparam int          SETTLE_CYCLES = 50;    // > divide latency

    logic i_clk = 1'b0;
    logic i_rst_n;

    kic_key_if key_ch ();
    kic_res_if res_ch ();

    keypad_integer_calculator_top #(
        .OPERAND_WIDTH (16)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_ch),
        .o_res   (res_ch)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // calculator state as the bench sees it
    logic [15:0] calc_first;
    logic [15:0] calc_second;
    logic        calc_op_entered;
    logic        calc_result_shown;
    logic [2:0]  calc_pending;

    t_res display_queue[$];     // result words still owed by the block
    int   mismatch_count = 0;
    int   useful_keys    = 0;   // accepted keys that were not ignored
    bit   calm_phase     = 1'b0;
    bit   hold_stall_req = 1'b0;

    // ------------------------------------------------------------------------
    // predictor: applies one key word to the bench copy of the calculator
    // and returns the result word it must produce
    // ------------------------------------------------------------------------
    function automatic t_res calc_press(logic [1:0] k, logic [3:0] d, logic [1:0] o);
        t_res        r;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] q;
        logic [16:0] mag_a;
        logic [16:0] mag_b;
        r = '0;
        case (k)
            KEY_DIGIT: begin
                // digits above nine change nothing
                if (d <= MAX_DIGIT) begin
                    if (calc_op_entered)
                        calc_second = calc_second * DECIMAL_BASE + {12'd0, d};
                    else
                        calc_first = calc_first * DECIMAL_BASE + {12'd0, d};
                    r.event_res = EV_DIGIT;
                end
            end
            KEY_OPERATOR: begin
                // refused while an operator waits for its equals
                if (!calc_op_entered || calc_result_shown) begin
                    calc_op_entered   = 1'b1;
                    calc_result_shown = 1'b0;
                    case (o)
                        OPR_DIVIDE:   calc_pending = PEND_DIV;
                        OPR_MULTIPLY: calc_pending = PEND_MUL;
                        OPR_SUBTRACT: calc_pending = PEND_SUB;
                        default:      calc_pending = PEND_ADD;
                    endcase
                    r.event_res = EV_OPERATOR;
                end
            end
            KEY_EQUALS: begin
                // nothing latched yet: ignored
                if (calc_pending != PEND_NONE) begin
                    a = calc_first;
                    b = calc_second;
                    q = a;
                    case (calc_pending)
                        PEND_DIV: begin
                            if (b == 16'd0) begin
                                // divide by zero keeps the first operand
                                r.divide_error = 1'b1;
                            end else begin
                                // truncate toward zero on magnitudes, then
                                // fix the sign; -32768 / -1 wraps to itself
                                mag_a = {1'b0, a[15] ? 16'(-a) : a};
                                mag_b = {1'b0, b[15] ? 16'(-b) : b};
                                q = 16'(mag_a / mag_b);
                                if (a[15] ^ b[15])
                                    q = 16'(-q);
                            end
                        end
                        PEND_MUL: q = a * b;
                        PEND_SUB: q = a - b;
                        default:  q = a + b;
                    endcase
                    calc_first        = q;
                    calc_second       = '0;
                    calc_result_shown = 1'b1;
                    r.event_res       = EV_RESULT;
                    r.value           = q;
                end
            end
            default: begin
                // clear keeps the latched operation
                calc_first        = '0;
                calc_second       = '0;
                calc_op_entered   = 1'b0;
                calc_result_shown = 1'b0;
                r.event_res       = EV_CLEARED;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // key side
    // ------------------------------------------------------------------------
    // offers one key word, maybe after a short gap, and records its result
    // once accepted; valid stays high so back-to-back keys need no re-raise
    task automatic send_key(input logic [1:0] k, input logic [3:0] d, input logic [1:0] o);
        t_res want;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            key_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        key_ch.valid     <= 1'b1;
        key_ch.op        <= k;
        key_ch.digit     <= d;
        key_ch.operation <= o;
        @(posedge i_clk);
        while (!key_ch.ready) @(posedge i_clk);
        want = calc_press(k, d, o);
        display_queue.push_back(want);
        if (want.event_res != EV_IGNORED)
            useful_keys++;
    endtask

    // digit keys with random unused operation field
    task automatic send_number(input int n_digits);
        repeat (n_digits)
            send_key(KEY_DIGIT, 4'($urandom_range(0, 9)), 2'($urandom_range(0, 3)));
    endtask

    task automatic send_operator(input logic [1:0] o);
        send_key(KEY_OPERATOR, 4'($urandom_range(0, 15)), o);
    endtask

    task automatic send_simple(input logic [1:0] k);
        send_key(k, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
    endtask

    task automatic send_digits(input logic [3:0] d[]);
        foreach (d[i])
            send_key(KEY_DIGIT, d[i], 2'($urandom_range(0, 3)));
    endtask

    // sender pauses until every owed result word has come back
    task automatic await_display_drain;
        key_ch.valid <= 1'b0;
        do @(posedge i_clk); while (display_queue.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall bursts, one long hold on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        forever begin
            if (hold_stall_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_stall_req = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // compare every accepted result word with the oldest one owed
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (display_queue.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result word ev=%0d value=%0d div_err=%0b",
                         $time, res_ch.event_res, res_ch.value, res_ch.divide_error);
            end else begin
                want = display_queue.pop_front();
                if (res_ch.event_res !== want.event_res) begin
                    mismatch_count++;
                    $display("%0t: event_res expected %0d actual %0d",
                             $time, want.event_res, res_ch.event_res);
                end
                if (res_ch.value !== want.value) begin
                    mismatch_count++;
                    $display("%0t: value expected %0d actual %0d",
                             $time, want.value, res_ch.value);
                end
                if (res_ch.divide_error !== want.divide_error) begin
                    mismatch_count++;
                    $display("%0t: divide_error expected %0b actual %0b",
                             $time, want.divide_error, res_ch.divide_error);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------
    // equals before any operator and digits above nine do nothing
    task automatic test_ignored_keys;
        send_simple(KEY_EQUALS);
        send_key(KEY_DIGIT, 4'd15, OPR_ADD);
        send_key(KEY_DIGIT, 4'd10, OPR_DIVIDE);
    endtask

    // 32768 wraps to the most negative value; divide by zero keeps it;
    // then 65535 (-1) typed after the result lands in the second operand
    task automatic test_division_edges;
        send_digits('{4'd3, 4'd2, 4'd7, 4'd6, 4'd8});
        send_operator(OPR_DIVIDE);
        send_operator(OPR_ADD);            // refused, divide stays latched
        send_simple(KEY_EQUALS);           // second operand is zero
        send_digits('{4'd6, 4'd5, 4'd5, 4'd3, 4'd5});
        send_simple(KEY_EQUALS);           // most negative over minus one
    endtask

    // operators are taken again right after a result; multiply wraps
    task automatic test_chained_operators;
        send_operator(OPR_MULTIPLY);
        send_key(KEY_DIGIT, 4'd9, OPR_SUBTRACT);
        send_simple(KEY_EQUALS);
        send_operator(OPR_SUBTRACT);
        send_key(KEY_DIGIT, 4'd1, OPR_MULTIPLY);
        send_simple(KEY_EQUALS);
    endtask

    // clear keeps the latched subtract; equals still applies it
    task automatic test_clear_keeps_operation;
        send_simple(KEY_CLEAR);
        send_key(KEY_DIGIT, 4'd0, OPR_ADD);
        send_simple(KEY_EQUALS);
        send_operator(OPR_ADD);
        send_simple(KEY_EQUALS);
    endtask

    // result side held off while keys keep coming, so the block fills up
    // and drops its key ready
    task automatic test_result_backpressure;
        await_display_drain();
        hold_stall_req = 1'b1;
        send_simple(KEY_CLEAR);
        send_number(3);
        send_operator(OPR_ADD);
        send_number(3);
        send_simple(KEY_EQUALS);
        send_operator(OPR_DIVIDE);
        send_number(1);
        send_simple(KEY_EQUALS);
        await_display_drain();
    endtask

    // one calculation with random content, sometimes chained
    task automatic send_random_calculation;
        int n_digits;
        if ($urandom_range(0, 3) == 0)
            send_simple(KEY_CLEAR);
        // mostly short numbers, now and then five digits to wrap
        n_digits = ($urandom_range(0, 7) == 0) ? 5 : $urandom_range(0, 3);
        send_number(n_digits);
        repeat ($urandom_range(1, 3)) begin
            send_operator(2'($urandom_range(0, 3)));
            n_digits = ($urandom_range(0, 7) == 0) ? 5 : $urandom_range(0, 2);
            send_number(n_digits);
            send_simple(KEY_EQUALS);
        end
    endtask

    // mostly well-formed calculations, some raw noise and drain pauses
    task automatic test_random_keys;
        int pick;
        while (useful_keys < KEY_TARGET) begin
            if (useful_keys >= CALM_FROM)
                calm_phase = 1'b1;
            pick = $urandom_range(0, 39);
            if (pick == 0 && !calm_phase) begin
                await_display_drain();
            end else if (pick < 6) begin
                repeat ($urandom_range(1, 3))
                    send_key(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                             2'($urandom_range(0, 3)));
            end else begin
                send_random_calculation();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        key_ch.valid     <= 1'b0;
        key_ch.op        <= KEY_DIGIT;
        key_ch.digit     <= '0;
        key_ch.operation <= OPR_DIVIDE;
        calc_first        = '0;
        calc_second       = '0;
        calc_op_entered   = 1'b0;
        calc_result_shown = 1'b0;
        calc_pending      = PEND_NONE;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ignored_keys();
        test_division_edges();
        test_chained_operators();
        test_clear_keeps_operation();
        test_result_backpressure();
        test_random_keys();

        // let any stray result word show up before the verdict
        await_display_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
